FILE: rtl/core/rtcbcd_pkg.sv
// Shared types and constants of the RTC register file.
package rtcbcd_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int TIME_REGS   = 7;
    localparam int TIME_W      = 3;

    localparam logic [7:0] IDLE_BYTE = 8'hFF;
    localparam int         MODE_BIT  = 6;
    localparam logic [7:0] MODE_FLAG = 8'h40;
    localparam logic [7:0] PM_FLAG   = 8'h20;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } ctrl_cmd_t;

endpackage

FILE: rtl/core/rtcbcd_ctrl.sv
// Sequencer: capture, execute and respond steps plus result valid flag.
module rtcbcd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rtcbcd_pkg::ctrl_cmd_t ctrl_cmd
);
    import rtcbcd_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        ctrl_cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                ctrl_cmd.capture = s_valid;
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                ctrl_cmd.execute = 1'b1;
                state_next       = ST_RESP;
            end
            ST_RESP: begin
                // output slot free, or being emptied this cycle
                if (!out_valid_reg || m_ready) begin
                    ctrl_cmd.load_out = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (ctrl_cmd.load_out)  out_valid_next = 1'b1;
        else if (m_ready)       out_valid_next = 1'b0;
        else                    out_valid_next = out_valid_reg;
    end

    assign m_valid = out_valid_reg;

endmodule

FILE: rtl/core/rtcbcd_time_enc.sv
// Binary to BCD encoder for the seven time registers.
module rtcbcd_time_enc (
    input  logic [5:0] seconds,
    input  logic [5:0] minutes,
    input  logic [4:0] hours,
    input  logic [2:0] weekday,
    input  logic [4:0] day_of_month,
    input  logic [3:0] month,
    input  logic [6:0] year,
    input  logic       twelve_hour,
    output logic [7:0] time_byte [rtcbcd_pkg::TIME_REGS]
);
    import rtcbcd_pkg::*;

    // tens = v*103 >> 10 is exact for v up to 178
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [7:0]  units;
        prod  = 14'(v) * 14'd103;
        tens  = prod[13:10];
        units = 8'(v) - 8'(tens) * 8'd10;
        return {tens, units[3:0]};
    endfunction

    logic [6:0] year_mod;
    logic [4:0] hour12;
    logic [7:0] hour_byte;

    always_comb begin
        year_mod = (year >= 7'd100) ? (year - 7'd100) : year;

        if (hours >= 5'd24)      hour12 = hours - 5'd24;
        else if (hours >= 5'd12) hour12 = hours - 5'd12;
        else                     hour12 = hours;
        if (hour12 == 5'd0) hour12 = 5'd12;

        if (twelve_hour) begin
            hour_byte = to_bcd(7'(hour12)) | MODE_FLAG;
            if (hours > 5'd11) hour_byte = hour_byte | PM_FLAG;
        end else begin
            hour_byte = to_bcd(7'(hours));
        end

        time_byte[0] = to_bcd(7'(seconds));
        time_byte[1] = to_bcd(7'(minutes));
        time_byte[2] = hour_byte;
        time_byte[3] = 8'(weekday) + 8'd1;
        time_byte[4] = to_bcd(7'(day_of_month));
        time_byte[5] = to_bcd(7'(month) + 7'd1);
        time_byte[6] = to_bcd(year_mod);
    end

endmodule

FILE: rtl/core/rtcbcd_dpath.sv
// Datapath: captured beat, time registers, register store, pointer, result byte.
module rtcbcd_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtcbcd_pkg::ctrl_cmd_t ctrl_cmd,
    input  logic [1:0]            s_command,
    input  logic [7:0]            s_data_byte,
    input  logic [5:0]            s_seconds_now,
    input  logic [5:0]            s_minutes_now,
    input  logic [4:0]            s_hours_now,
    input  logic [2:0]            s_weekday_now,
    input  logic [4:0]            s_day_of_month_now,
    input  logic [3:0]            s_month_now,
    input  logic [6:0]            s_year_now,
    output logic [7:0]            m_read_data
);
    import rtcbcd_pkg::*;

    // captured beat
    cmd_e_t     cmd_reg;
    logic [7:0] data_reg;
    logic [5:0] sec_reg, min_reg;
    logic [4:0] hour_reg, dom_reg;
    logic [2:0] wday_reg;
    logic [3:0] mon_reg;
    logic [6:0] year_reg;

    // architectural state
    logic [7:0]             time_reg [TIME_REGS];
    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic                   pending_reg;
    logic                   mode_reg;

    // read path
    logic [7:0] mem_rd_reg, time_rd_reg, read_data_reg;
    logic       entry_valid_reg, time_hit_reg;

    logic [7:0]        enc_byte [TIME_REGS];
    logic              ptr_is_time;
    logic [TIME_W-1:0] time_idx;
    logic              mem_wr;

    rtcbcd_time_enc u_enc (
        .seconds      (sec_reg),
        .minutes      (min_reg),
        .hours        (hour_reg),
        .weekday      (wday_reg),
        .day_of_month (dom_reg),
        .month        (mon_reg),
        .year         (year_reg),
        .twelve_hour  (mode_reg),
        .time_byte    (enc_byte)
    );

    assign ptr_is_time = (ptr_reg < PTR_W'(TIME_REGS));
    assign time_idx    = ptr_reg[TIME_W-1:0];
    assign ptr_next    = (ptr_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign mem_wr      = ctrl_cmd.execute && (cmd_reg == CMD_WRITE) && !pending_reg
                         && !ptr_is_time;

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.capture) begin
            cmd_reg  <= cmd_e_t'(s_command);
            data_reg <= s_data_byte;
            sec_reg  <= s_seconds_now;
            min_reg  <= s_minutes_now;
            hour_reg <= s_hours_now;
            wday_reg <= s_weekday_now;
            dom_reg  <= s_day_of_month_now;
            mon_reg  <= s_month_now;
            year_reg <= s_year_now;
        end
    end

    // register store, registered read
    always_ff @(posedge aclk) begin
        if (mem_wr) mem[ptr_reg] <= data_reg;
        if (ctrl_cmd.execute) begin
            mem_rd_reg  <= mem[ptr_reg];
            time_rd_reg <= time_reg[time_idx];
        end
        if (ctrl_cmd.load_out) begin
            if (cmd_reg == CMD_READ) begin
                if (time_hit_reg)         read_data_reg <= time_rd_reg;
                else if (entry_valid_reg) read_data_reg <= mem_rd_reg;
                else                      read_data_reg <= 8'h00;
            end else begin
                read_data_reg <= IDLE_BYTE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TIME_REGS; i++) time_reg[i] <= 8'h00;
            valid_reg       <= '0;
            ptr_reg         <= '0;
            pending_reg     <= 1'b0;
            mode_reg        <= 1'b0;
            entry_valid_reg <= 1'b0;
            time_hit_reg    <= 1'b0;
        end else if (ctrl_cmd.execute) begin
            entry_valid_reg <= valid_reg[ptr_reg];
            time_hit_reg    <= ptr_is_time;
            unique case (cmd_reg)
                CMD_START: begin
                    for (int i = 0; i < TIME_REGS; i++) time_reg[i] <= enc_byte[i];
                    pending_reg <= 1'b1;
                end
                CMD_READ: begin
                    ptr_reg <= ptr_next;
                end
                CMD_WRITE: begin
                    if (pending_reg) begin
                        // depth is a power of two: low bits give the modulo
                        ptr_reg     <= data_reg[PTR_W-1:0];
                        pending_reg <= 1'b0;
                    end else begin
                        if (ptr_is_time) time_reg[time_idx] <= data_reg;
                        else             valid_reg[ptr_reg] <= 1'b1;
                        if (ptr_reg == PTR_W'(2)) mode_reg <= data_reg[MODE_BIT];
                        ptr_reg <= ptr_next;
                    end
                end
                CMD_STOP: ;
                default: ;
            endcase
        end
    end

    assign m_read_data = read_data_reg;

endmodule

FILE: rtl/core/rtc_register_file_bcd_latch.sv
// Top level of the RTC register file with BCD time latch.
//
// Usage:
//   Input channel (s_*): one bus event per beat. s_command is start, read,
//   write or stop; s_data_byte is the byte of a write; the s_*_now fields
//   carry the current time in binary and are used on start only.
//   Result channel (m_*): exactly one beat per event. m_read_data holds the
//   register byte on a read and 0xFF on any other event.
//   Sequence: after acceptance the event passes an execute step and a
//   respond step; m_valid rises once the respond step has loaded the result.
//   Events do not overlap: the next event is taken only once the last one
//   has passed the controller sequence around the registered store read.
//   Stall: the result sits in an output register; the next event is taken
//   while it waits, and that event's result is held in its respond step
//   until m_ready empties the output register.
//   Reset (aresetn low, synchronous): pointer, pointer-load flag and hour
//   mode clear; time registers clear; every store entry reads zero through
//   per-entry valid bits, so no clearing pass is needed and the block is
//   ready as soon as reset is released.
module rtc_register_file_bcd_latch (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_data_byte,
    input  logic [5:0] s_seconds_now,
    input  logic [5:0] s_minutes_now,
    input  logic [4:0] s_hours_now,
    input  logic [2:0] s_weekday_now,
    input  logic [4:0] s_day_of_month_now,
    input  logic [3:0] s_month_now,
    input  logic [6:0] s_year_now,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);
    import rtcbcd_pkg::*;

    ctrl_cmd_t ctrl_cmd;

    // sequencer: owns handshakes and result valid
    rtcbcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .ctrl_cmd (ctrl_cmd)
    );

    // datapath: all register file state and the result byte
    rtcbcd_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl_cmd           (ctrl_cmd),
        .s_command          (s_command),
        .s_data_byte        (s_data_byte),
        .s_seconds_now      (s_seconds_now),
        .s_minutes_now      (s_minutes_now),
        .s_hours_now        (s_hours_now),
        .s_weekday_now      (s_weekday_now),
        .s_day_of_month_now (s_day_of_month_now),
        .s_month_now        (s_month_now),
        .s_year_now         (s_year_now),
        .m_read_data        (m_read_data)
    );

    // one event in flight: no new beat right after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an event is in flight");

    // respond step follows the execute step after acceptance, unless the output is stalled
    a_respond_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 (ctrl_cmd.load_out || (m_valid && !m_ready)))
        else $error("result not produced on schedule");

    // a loaded result is presented next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.load_out |=> m_valid)
        else $error("loaded result not presented");

    // a taken result without reload leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !ctrl_cmd.load_out) |=> !m_valid)
        else $error("result beat repeated");

endmodule
